### hw/rtl/u2dos_pkg.sv
package u2dos_pkg;

	// Day of year at which each month starts, non-leap year.
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	localparam logic [8:0] FEB29_DOY = 9'd59;

	typedef struct packed {
		logic [3:0] month;   // 1..12
		logic [8:0] nl_day;  // day of year on the non-leap scale
	} month_t;

endpackage

### hw/rtl/unix_seconds_to_dos_datetime.sv
// Converts a Unix timestamp (s_tdata) to packed FAT/DOS time and date words after subtracting
// the signed timezone_offset register, written with timezone_offset_we; the user must write it only
// while no beat is in flight (the block does not enforce this). Leap years are every fourth year,
// 2100 included. Adjusted times before 1980-01-01 clamp to 1980-01-01 00:00:00 and times from
// 2108 on clamp to 2107-12-31 23:59:58, both with out_of_range set. The block is a seven-stage
// pipeline of short constant-reciprocal multiplies and compares that takes one beat per cycle
// unless it is full with its output stalled; a stage holds its beat while the next stage is full
// and cannot pass its own beat on, so a stalled output does not block input until it has filled.
module unix_seconds_to_dos_datetime (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               timezone_offset_we,
	input  logic signed [16:0] timezone_offset,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // [31:0] unix_seconds
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata    // [15:0] dos_time, [31:16] dos_date, [32] out_of_range
);
	import u2dos_pkg::*;

	localparam logic signed [34:0] EPOCH_1980 = 35'sd315532800;
	localparam logic signed [34:0] SPAN_SECS  = 35'sd4039372800;
	localparam logic [15:0] DOS_DATE_MIN = 16'h0021;
	localparam logic [15:0] DOS_TIME_MAX = 16'hBF7D;
	localparam logic [15:0] DOS_DATE_MAX = 16'hFF9F;

	logic signed [16:0] tz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q <= '0;
		end else if (timezone_offset_we) begin
			tz_q <= timezone_offset;
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	assign rdy7 = !v_s7 || m_tready;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	// s1: offset and range check
	logic signed [34:0] adj_c, rel_c;
	logic [31:0] rel_s1;
	logic lo_s1, hi_s1;

	assign adj_c = $signed({3'b000, s_tdata}) - 35'(tz_q);
	assign rel_c = adj_c - EPOCH_1980;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			rel_s1 <= rel_c[31:0];
			lo_s1  <= rel_c[34];
			hi_s1  <= !rel_c[34] && (rel_c >= SPAN_SECS);
		end
	end

	// s2: day estimate, 86400 = 128 * 675, low by at most one
	logic [47:0] dq_prod;
	logic [31:0] rel_s2;
	logic [15:0] q0_s2;
	logic lo_s2, hi_s2;

	assign dq_prod = 48'(rel_s1[31:7]) * 48'd6362914;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			rel_s2 <= rel_s1;
			q0_s2  <= dq_prod[47:32];
			lo_s2  <= lo_s1;
			hi_s2  <= hi_s1;
		end
	end

	// s3: remainder and correction
	logic [32:0] dr_prod;
	logic [32:0] rem_c;
	logic [17:0] rem18;
	logic [15:0] day_s3;
	logic [16:0] secs_s3;
	logic lo_s3, hi_s3;

	assign dr_prod = 33'(q0_s2) * 33'd86400;
	assign rem_c   = {1'b0, rel_s2} - dr_prod;
	assign rem18   = rem_c[17:0];

	always_ff @(posedge clk) begin
		if (rdy3) begin
			if (rem18 >= 18'd86400) begin
				day_s3  <= q0_s2 + 16'd1;
				secs_s3 <= 17'(rem18 - 18'd86400);
			end else begin
				day_s3  <= q0_s2;
				secs_s3 <= rem18[16:0];
			end
			lo_s3 <= lo_s2;
			hi_s3 <= hi_s2;
		end
	end

	// s4: year estimate and hours
	logic [31:0] y_prod;
	logic [35:0] h_prod;
	logic [15:0] day_s4;
	logic [16:0] secs_s4;
	logic [7:0]  y0_s4;
	logic [4:0]  hrs_s4;
	logic lo_s4, hi_s4;

	assign y_prod = 32'(day_s3) * 32'd45965;
	assign h_prod = 36'(secs_s3) * 36'd298262;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			day_s4  <= day_s3;
			secs_s4 <= secs_s3;
			y0_s4   <= y_prod[31:24];
			hrs_s4  <= h_prod[34:30];
			lo_s4   <= lo_s3;
			hi_s4   <= hi_s3;
		end
	end

	// s5: leap-day correction of the year, day of year, seconds within the hour
	logic [7:0]  y1_c;
	logic [16:0] base0_c, base1_c;
	logic [16:0] ms_c;
	logic [6:0]  yr_s5;
	logic [8:0]  doy_s5;
	logic [11:0] ms_s5;
	logic [4:0]  hrs_s5;
	logic lo_s5, hi_s5;

	assign y1_c    = y0_s4 - 8'd1;
	assign base0_c = 17'(y0_s4) * 17'd365 + 17'((9'(y0_s4) + 9'd3) >> 2);
	assign base1_c = 17'(y1_c) * 17'd365 + 17'((9'(y1_c) + 9'd3) >> 2);
	assign ms_c    = secs_s4 - 17'(hrs_s4) * 17'd3600;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			if (base0_c > {1'b0, day_s4}) begin
				yr_s5  <= y1_c[6:0];
				doy_s5 <= 9'({1'b0, day_s4} - base1_c);
			end else begin
				yr_s5  <= y0_s4[6:0];
				doy_s5 <= 9'({1'b0, day_s4} - base0_c);
			end
			ms_s5  <= ms_c[11:0];
			hrs_s5 <= hrs_s4;
			lo_s5  <= lo_s4;
			hi_s5  <= hi_s4;
		end
	end

	// s6: month and minutes
	month_t mres;
	logic [24:0] m_prod;
	logic [6:0]  yr_s6;
	month_t      mon_s6;
	logic [11:0] ms_s6;
	logic [5:0]  mins_s6;
	logic [4:0]  hrs_s6;
	logic lo_s6, hi_s6;

	u2dos_month u_month (
		.doy  (doy_s5),
		.leap (yr_s5[1:0] == 2'b00),
		.res  (mres)
	);

	assign m_prod = 25'(ms_s5) * 25'd4370;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			yr_s6   <= yr_s5;
			mon_s6  <= mres;
			ms_s6   <= ms_s5;
			mins_s6 <= m_prod[23:18];
			hrs_s6  <= hrs_s5;
			lo_s6   <= lo_s5;
			hi_s6   <= hi_s5;
		end
	end

	// s7: day of month, seconds, pack and clamp
	logic [3:0]  midx;
	logic [8:0]  dom_c;
	logic [11:0] sec_c;
	logic [15:0] time_c, date_c;
	logic [15:0] time_s7, date_s7;
	logic        oor_s7;

	assign midx   = mon_s6.month - 4'd1;
	assign dom_c  = mon_s6.nl_day - MONTH_START[midx] + 9'd1;
	assign sec_c  = ms_s6 - 12'(mins_s6) * 12'd60;
	assign time_c = {hrs_s6, mins_s6, sec_c[5:1]};
	assign date_c = {yr_s6, mon_s6.month, dom_c[4:0]};

	always_ff @(posedge clk) begin
		if (rdy7) begin
			priority if (lo_s6) begin
				time_s7 <= 16'h0000;
				date_s7 <= DOS_DATE_MIN;
				oor_s7  <= 1'b1;
			end else if (hi_s6) begin
				time_s7 <= DOS_TIME_MAX;
				date_s7 <= DOS_DATE_MAX;
				oor_s7  <= 1'b1;
			end else begin
				time_s7 <= time_c;
				date_s7 <= date_c;
				oor_s7  <= 1'b0;
			end
		end
	end

	assign m_tdata = {7'b0000000, oor_s7, date_s7, time_s7};

endmodule

### hw/rtl/u2dos_month.sv
module u2dos_month (
	input  logic [8:0]       doy,
	input  logic             leap,
	output u2dos_pkg::month_t res
);
	import u2dos_pkg::*;

	logic [8:0] nl;
	logic [3:0] cnt;

	always_comb begin
		cnt = 4'd0;
		if (leap && doy == FEB29_DOY) begin
			nl = FEB29_DOY;
			res.month = 4'd2;
		end else begin
			nl = (leap && doy > FEB29_DOY) ? doy - 9'd1 : doy;
			for (int m = 1; m < 12; m++) begin
				cnt = cnt + 4'(MONTH_START[m] <= nl);
			end
			res.month = cnt + 4'd1;
		end
		res.nl_day = nl;
	end

endmodule
